### rtl/core/tsrg_pkg.sv
// Package for the stepper speed-ramp generator.
// Holds phase codes, register indexes and the Q16.16 ramp constants.
package tsrg_pkg;

  typedef enum logic [1:0] {
    PH_STOP  = 2'd0,
    PH_ACCEL = 2'd1,
    PH_DECEL = 2'd2,
    PH_RUN   = 2'd3
  } phase_t;

  localparam logic [1:0] REG_ACCEL = 2'd0;
  localparam logic [1:0] REG_SPEED = 2'd1;
  localparam logic [1:0] REG_DECEL = 2'd2;

  localparam logic [63:0] PI2_Q16 = 64'd628318 * 64'd65536 / 64'd100000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_S_MIN,
    ST_S_ASQ,
    ST_S_SQRT,
    ST_S_FIRST_M,
    ST_S_FIRST_D,
    ST_S_SPD_M,
    ST_S_SPD_D,
    ST_S_ACC_M,
    ST_S_ACC_D,
    ST_S_DV_M,
    ST_S_DV_D,
    ST_S_FIN,
    ST_E_DIV,
    ST_E_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

endpackage

### rtl/core/trapezoid_step_ramp_generator.sv
// Stepper speed-ramp generator top level: sequencer, registers, APB port.
// Depends on tsrg_pkg, tsrg_divider, tsrg_sqrt and tsrg_mul.
//
// Usage: an input request carries mode and move_steps. Mode 0 plans a
// relative move (direction, minimum delay, first delay by square root,
// deceleration point); mode 1 is a timer compare event that returns the
// delay to program and toggles the pulse. Every second event advances the
// ramp (by a signed division recurrence when accelerating or decelerating)
// and, unless stopped, moves the position. Each request gives exactly one
// result request. A start of two or more steps runs six serial divides, a
// square root and four shift-add multiplies in turn; a start of zero or one
// step skips them. A compare event runs one serial divide when it advances
// the accelerate or decelerate ramp.
// One request is worked at a time; in_stall is high while busy or while
// a result waits. While out_stall is high the result holds and no new
// request is taken. Synchronous reset clears the ramp state and loads
// 100 into all three registers.
// Registers: accel_rate at 0x0, max_speed at 0x4, decel_rate at 0x8.
module trapezoid_step_ramp_generator #(
  parameter int STEPS_PER_REV = 200,
  parameter int TIMER_FREQ    = 100000
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic signed [31:0] move_steps,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        compare_delay,
  output logic               pulse_level,
  output logic               direction,
  output logic signed [31:0] position,
  output logic               moving,
  output logic [1:0]         phase,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [63:0] AT10  =
    64'd10 * 64'(TIMER_FREQ) * tsrg_pkg::PI2_Q16 / 64'(STEPS_PER_REV);
  localparam logic [63:0] ASQ   =
    64'd200000 * tsrg_pkg::PI2_Q16 / 64'(STEPS_PER_REV);
  localparam logic [63:0] AX200 =
    64'd200 * tsrg_pkg::PI2_Q16 / 64'(STEPS_PER_REV);
  localparam logic [63:0] T148  =
    64'(TIMER_FREQ) * 64'd676 * 64'd65536 / 64'd10000;

  logic [15:0] accel_rate;
  logic [15:0] max_speed;
  logic [15:0] decel_rate;

  tsrg_pkg::phase_t ramp_phase;
  tsrg_pkg::state_t state;
  tsrg_pkg::state_t state_next;
  logic        dir_flag;
  logic [15:0] cur_delay;
  logic [15:0] run_delay;
  logic [31:0] decel_start_step;
  logic [31:0] decel_count_init;
  logic [31:0] ramp_count;
  logic [31:0] steps_done;
  logic [31:0] div_remainder;
  logic [15:0] last_accel_delay;
  logic        toggle_bit;
  logic [31:0] position_reg;
  logic        moving_flag;

  logic [31:0] mag;
  logic [63:0] tmp_a;
  logic [63:0] speed_lim;
  logic [15:0] first_delay;
  logic        num_neg;
  logic        den_neg;
  logic [15:0] delay_out;

  tsrg_pkg::div_req_t div_req;
  logic        div_done;
  logic [63:0] div_quo;
  logic [63:0] div_rem;
  logic        sq_start;
  logic        sq_done;
  logic [31:0] sq_root;
  logic        mul_start;
  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic        mul_done;
  logic [63:0] mul_prod;

  logic [15:0] acc_nz;
  logic [15:0] spd_nz;
  logic [15:0] dec_nz;
  logic        accepted;

  assign acc_nz = (accel_rate == 16'd0) ? 16'd1 : accel_rate;
  assign spd_nz = (max_speed == 16'd0) ? 16'd1 : max_speed;
  assign dec_nz = (decel_rate == 16'd0) ? 16'd1 : decel_rate;
  assign accepted = in_valid && !in_stall;
  assign in_stall = (state != tsrg_pkg::ST_IDLE);
  assign pready = 1'b1;

  tsrg_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo),
    .rem  (div_rem)
  );

  tsrg_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (div_quo),
    .done  (sq_done),
    .root  (sq_root)
  );

  tsrg_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_rate <= 16'd100;
      max_speed  <= 16'd100;
      decel_rate <= 16'd100;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        tsrg_pkg::REG_ACCEL: accel_rate <= pwdata[15:0];
        tsrg_pkg::REG_SPEED: max_speed  <= pwdata[15:0];
        tsrg_pkg::REG_DECEL: decel_rate <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      tsrg_pkg::REG_ACCEL: prdata = {16'd0, accel_rate};
      tsrg_pkg::REG_SPEED: prdata = {16'd0, max_speed};
      tsrg_pkg::REG_DECEL: prdata = {16'd0, decel_rate};
      default:             prdata = 32'd0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      tsrg_pkg::ST_IDLE: begin
        if (accepted) begin
          if (!mode) state_next = tsrg_pkg::ST_S_MIN;
          else if (toggle_bit && (ramp_phase == tsrg_pkg::PH_ACCEL ||
                                   ramp_phase == tsrg_pkg::PH_DECEL))
            state_next = tsrg_pkg::ST_E_DIV;
          else state_next = tsrg_pkg::ST_E_FIN;
        end
      end
      tsrg_pkg::ST_E_DIV:     if (div_done) state_next = tsrg_pkg::ST_E_FIN;
      tsrg_pkg::ST_E_FIN:     state_next = tsrg_pkg::ST_OUT;
      tsrg_pkg::ST_S_MIN: begin
        if (mag <= 32'd1) state_next = tsrg_pkg::ST_S_FIN;
        else if (div_done) state_next = tsrg_pkg::ST_S_ASQ;
      end
      tsrg_pkg::ST_S_ASQ:     if (div_done) state_next = tsrg_pkg::ST_S_SQRT;
      tsrg_pkg::ST_S_SQRT:    if (sq_done) state_next = tsrg_pkg::ST_S_FIRST_M;
      tsrg_pkg::ST_S_FIRST_M: if (mul_done) state_next = tsrg_pkg::ST_S_FIRST_D;
      tsrg_pkg::ST_S_FIRST_D: if (div_done) state_next = tsrg_pkg::ST_S_SPD_M;
      tsrg_pkg::ST_S_SPD_M:   if (mul_done) state_next = tsrg_pkg::ST_S_SPD_D;
      tsrg_pkg::ST_S_SPD_D:   if (div_done) state_next = tsrg_pkg::ST_S_ACC_M;
      tsrg_pkg::ST_S_ACC_M:   if (mul_done) state_next = tsrg_pkg::ST_S_ACC_D;
      tsrg_pkg::ST_S_ACC_D:   if (div_done) state_next = tsrg_pkg::ST_S_DV_M;
      tsrg_pkg::ST_S_DV_M:    if (mul_done) state_next = tsrg_pkg::ST_S_DV_D;
      tsrg_pkg::ST_S_DV_D:    if (div_done) state_next = tsrg_pkg::ST_S_FIN;
      tsrg_pkg::ST_S_FIN:     state_next = tsrg_pkg::ST_OUT;
      tsrg_pkg::ST_OUT:       if (!out_stall) state_next = tsrg_pkg::ST_IDLE;
      default:                state_next = tsrg_pkg::ST_IDLE;
    endcase
  end

  // launch a serial unit on entry to each working state
  logic launch;
  logic [63:0] e_num;
  logic [63:0] e_den;
  logic [33:0] den_s;
  logic [33:0] num_s;
  assign num_s = {17'd0, cur_delay, 1'b0} + {{2{div_remainder[31]}}, div_remainder};
  assign den_s = {ramp_count, 2'b01};
  assign e_num = num_s[33] ? 64'(-{{30{num_s[33]}}, num_s}) : 64'(num_s);
  assign e_den = den_s[33] ? 64'(-{{30{den_s[33]}}, den_s}) : 64'(den_s);
  assign num_neg = num_s[33];
  assign den_neg = den_s[33];

  always_comb begin
    div_req   = '0;
    sq_start  = 1'b0;
    mul_start = 1'b0;
    mul_a     = 64'd0;
    mul_b     = 64'd0;
    if (launch) begin
      case (state)
        tsrg_pkg::ST_S_MIN: begin
          div_req.start = (mag > 32'd1);
          div_req.num   = AT10;
          div_req.den   = {32'd0, spd_nz, 16'd0};
        end
        tsrg_pkg::ST_S_ASQ: begin
          div_req.start = 1'b1;
          div_req.num   = {ASQ[47:0], 16'd0};
          div_req.den   = {48'd0, acc_nz};
        end
        tsrg_pkg::ST_S_SQRT: sq_start = 1'b1;
        tsrg_pkg::ST_S_FIRST_M: begin
          mul_start = 1'b1;
          mul_a     = T148;
          mul_b     = {32'd0, sq_root};
        end
        tsrg_pkg::ST_S_FIRST_D: begin
          div_req.start = 1'b1;
          div_req.num   = mul_prod;
          div_req.den   = 64'd10 << 32;
        end
        tsrg_pkg::ST_S_SPD_M: begin
          mul_start = 1'b1;
          mul_a     = {32'd0, spd_nz, 16'd0} * 64'd10;
          mul_b     = {48'd0, spd_nz};
        end
        tsrg_pkg::ST_S_SPD_D: begin
          div_req.start = 1'b1;
          div_req.num   = mul_prod;
          div_req.den   = tmp_a;
        end
        tsrg_pkg::ST_S_ACC_M: begin
          mul_start = 1'b1;
          mul_a     = {32'd0, mag};
          mul_b     = {48'd0, dec_nz};
        end
        tsrg_pkg::ST_S_ACC_D: begin
          div_req.start = 1'b1;
          div_req.num   = mul_prod;
          div_req.den   = {47'd0, {1'b0, acc_nz} + {1'b0, dec_nz}};
        end
        tsrg_pkg::ST_S_DV_M: begin
          mul_start = 1'b1;
          mul_a     = speed_lim;
          mul_b     = {48'd0, acc_nz};
        end
        tsrg_pkg::ST_S_DV_D: begin
          div_req.start = 1'b1;
          div_req.num   = mul_prod;
          div_req.den   = {48'd0, dec_nz};
        end
        tsrg_pkg::ST_E_DIV: begin
          div_req.start = 1'b1;
          div_req.num   = e_num;
          div_req.den   = e_den;
        end
        default: ;
      endcase
    end
  end

  // recurrence result, signs restored (truncation toward zero)
  logic [63:0] q_s;
  logic [63:0] r_s;
  logic [31:0] r_sat;
  logic [63:0] nd_s;
  logic [15:0] nd16;
  logic [31:0] steps_inc;
  logic [31:0] rc_inc;
  logic [63:0] acc_lim;
  logic [63:0] dv;
  assign q_s  = (num_neg ^ den_neg) ? -div_quo : div_quo;
  assign r_s  = num_neg ? -div_rem : div_rem;
  assign r_sat = ((r_s[63:31] == 33'd0) || (r_s[63:31] == {33{1'b1}})) ? r_s[31:0] :
                 (r_s[63] ? 32'h8000_0000 : 32'h7FFF_FFFF);
  assign nd_s = {48'd0, cur_delay} - q_s;
  assign nd16 = nd_s[63] ? 16'd0 : ((nd_s[62:16] != 47'd0) ? 16'hFFFF : nd_s[15:0]);
  assign steps_inc = steps_done + 32'd1;
  assign rc_inc    = ramp_count + 32'd1;
  assign acc_lim   = (tmp_a == 64'd0) ? 64'd1 : tmp_a;
  assign dv = (acc_lim <= speed_lim) ? (acc_lim - {32'd0, mag}) :
              ((div_quo == 64'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : -div_quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= tsrg_pkg::ST_IDLE;
      launch           <= 1'b0;
      out_valid        <= 1'b0;
      ramp_phase       <= tsrg_pkg::PH_STOP;
      dir_flag         <= 1'b0;
      cur_delay        <= 16'd0;
      run_delay        <= 16'd0;
      decel_start_step <= 32'd0;
      decel_count_init <= 32'd0;
      ramp_count       <= 32'd0;
      steps_done       <= 32'd0;
      div_remainder    <= 32'd0;
      last_accel_delay <= 16'd0;
      toggle_bit       <= 1'b0;
      position_reg     <= 32'd0;
      moving_flag      <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= (state_next != state) && (state_next != tsrg_pkg::ST_OUT) &&
                (state_next != tsrg_pkg::ST_IDLE);
      if (state == tsrg_pkg::ST_OUT && !out_stall) out_valid <= 1'b0;
      case (state)
        tsrg_pkg::ST_IDLE: begin
          if (accepted) begin
            dir_flag <= mode ? dir_flag : move_steps[31];
            mag <= move_steps[31] ? -move_steps : move_steps;
            if (mode) begin
              delay_out  <= cur_delay;
              toggle_bit <= ~toggle_bit;
              if (toggle_bit && (ramp_phase == tsrg_pkg::PH_ACCEL ||
                                 ramp_phase == tsrg_pkg::PH_DECEL))
                ramp_count <= rc_inc;
            end
          end
        end
        tsrg_pkg::ST_E_DIV: ;
        tsrg_pkg::ST_E_FIN: begin
          if (!toggle_bit) begin
            case (ramp_phase)
              tsrg_pkg::PH_STOP: begin
                steps_done    <= 32'd0;
                div_remainder <= 32'd0;
                moving_flag   <= 1'b0;
                cur_delay     <= 16'd0;
              end
              tsrg_pkg::PH_ACCEL: begin
                steps_done   <= steps_inc;
                position_reg <= dir_flag ? position_reg - 32'd1 : position_reg + 32'd1;
                if (steps_inc >= decel_start_step) begin
                  div_remainder <= r_sat;
                  cur_delay     <= nd16;
                  ramp_count    <= decel_count_init;
                  ramp_phase    <= tsrg_pkg::PH_DECEL;
                end else if (nd16 <= run_delay) begin
                  last_accel_delay <= nd16;
                  cur_delay        <= run_delay;
                  div_remainder    <= 32'd0;
                  ramp_phase       <= tsrg_pkg::PH_RUN;
                end else begin
                  div_remainder <= r_sat;
                  cur_delay     <= nd16;
                end
              end
              tsrg_pkg::PH_RUN: begin
                steps_done   <= steps_inc;
                position_reg <= dir_flag ? position_reg - 32'd1 : position_reg + 32'd1;
                if (steps_inc >= decel_start_step) begin
                  ramp_count <= decel_count_init;
                  cur_delay  <= last_accel_delay;
                  ramp_phase <= tsrg_pkg::PH_DECEL;
                end else begin
                  cur_delay <= run_delay;
                end
              end
              default: begin
                steps_done    <= steps_inc;
                position_reg  <= dir_flag ? position_reg - 32'd1 : position_reg + 32'd1;
                div_remainder <= r_sat;
                cur_delay     <= nd16;
                if (!ramp_count[31]) ramp_phase <= tsrg_pkg::PH_STOP;
              end
            endcase
          end
          out_valid <= 1'b1;
        end
        tsrg_pkg::ST_S_MIN: if (div_done) run_delay <= (div_quo > 64'd65535) ?
                              16'hFFFF : div_quo[15:0];
        tsrg_pkg::ST_S_FIRST_D: if (div_done) first_delay <= (div_quo > 64'd65535) ?
                                  16'hFFFF : div_quo[15:0];
        tsrg_pkg::ST_S_SPD_M: if (launch) tmp_a <= AX200 * {48'd0, acc_nz};
        tsrg_pkg::ST_S_SPD_D: begin
          if (div_done) speed_lim <= (div_quo > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF :
                                     ((div_quo == 64'd0) ? 64'd1 : div_quo);
        end
        tsrg_pkg::ST_S_ACC_D: if (div_done) tmp_a <= div_quo;
        tsrg_pkg::ST_S_FIN: begin
          moving_flag <= 1'b1;
          if (mag == 32'd1) begin
            ramp_count <= 32'hFFFF_FFFF;
            ramp_phase <= tsrg_pkg::PH_DECEL;
            cur_delay  <= 16'd1000;
            delay_out  <= 16'd1000;
          end else if (mag != 32'd0) begin
            decel_count_init <= dv[31:0];
            decel_start_step <= mag + dv[31:0];
            ramp_count       <= 32'd0;
            if (first_delay <= run_delay) begin
              cur_delay  <= run_delay;
              delay_out  <= run_delay;
              ramp_phase <= tsrg_pkg::PH_RUN;
            end else begin
              cur_delay  <= first_delay;
              delay_out  <= first_delay;
              ramp_phase <= tsrg_pkg::PH_ACCEL;
            end
          end else begin
            delay_out <= cur_delay;
          end
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign compare_delay = delay_out;
  assign pulse_level   = toggle_bit;
  assign direction     = dir_flag;
  assign position      = position_reg;
  assign moving        = moving_flag;
  assign phase         = ramp_phase;

endmodule

### rtl/core/tsrg_divider.sv
// Bit-serial unsigned 64-bit restoring divider, one quotient bit per cycle.
// Depends on tsrg_pkg.
module tsrg_divider (
  input  logic              clk,
  input  logic              rst,
  input  tsrg_pkg::div_req_t req,
  output logic              done,
  output logic [63:0]       quo,
  output logic [63:0]       rem
);

  logic [63:0] den;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] trial;

  assign trial = {1'b0, rem[62:0], quo[63]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
        den  <= req.den;
        quo  <= req.num;
        rem  <= 64'd0;
      end else if (busy) begin
        if ((rem[63] == 1'b0) && !trial[64]) begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b1};
        end else if (rem[63]) begin
          rem <= {rem[62:0], quo[63]} - den;
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/core/tsrg_sqrt.sv
// Digit-serial integer square root, two radicand bits per cycle.
// Standalone; used by the top level for the first delay.
module tsrg_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] value,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] rad;
  logic [33:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [33:0] shifted;
  logic [33:0] trial;

  assign shifted = {rem[31:0], rad[63:62]};
  assign trial   = shifted - {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rad  <= value;
        rem  <= 34'd0;
        root <= 32'd0;
        cnt  <= 6'd0;
      end else if (busy) begin
        rad <= {rad[61:0], 2'b00};
        if (!trial[33]) begin
          rem  <= trial;
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= shifted;
          root <= {root[30:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/core/tsrg_mul.sv
// Shift-add multiplier, 64 by 64 truncated to 64 bits, one bit per cycle.
// Standalone; used by the top level for ramp planning products.
module tsrg_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] prod
);

  logic [63:0] ma;
  logic [63:0] mb;
  logic        busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        ma   <= a;
        mb   <= b;
        prod <= 64'd0;
      end else if (busy) begin
        if (mb[0]) prod <= prod + ma;
        ma <= {ma[62:0], 1'b0};
        mb <= {1'b0, mb[63:1]};
        if (mb[63:1] == 63'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### tb/tb_trapezoid_step_ramp_generator.sv
// Testbench for the stepper speed-ramp generator: directed and random moves
// and compare events, checked against an in-bench ramp predictor.
// Depends on tsrg_pkg and trapezoid_step_ramp_generator.
module tb_trapezoid_step_ramp_generator;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0]       dly;
    logic              pulse;
    logic              dir;
    logic [31:0]       pos;
    logic              mov;
    tsrg_pkg::phase_t  ph;
  } ramp_out_t;

  class ramp_scoreboard;
    logic [15:0] acc_r, spd_r, dec_r;
    tsrg_pkg::phase_t ph;
    logic dir, tog, mov;
    logic [15:0] delay, run_delay, last_acc;
    logic [31:0] dstart, dcount, rcount, sdone, pos;
    longint rem;
    ramp_out_t pending[$];
    int errors;

    function void reset_state();
      acc_r = 100; spd_r = 100; dec_r = 100;
      ph = tsrg_pkg::PH_STOP; dir = 0; tog = 0; mov = 0;
      delay = 0; run_delay = 0; last_acc = 0;
      dstart = 0; dcount = 0; rcount = 0; sdone = 0; pos = 0; rem = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] v);
      if (idx == tsrg_pkg::REG_ACCEL) acc_r = v;
      else if (idx == tsrg_pkg::REG_SPEED) spd_r = v;
      else if (idx == tsrg_pkg::REG_DECEL) dec_r = v;
    endfunction

    function longint unsigned sat16(longint unsigned v);
      return v > 65535 ? 65535 : v;
    endfunction

    function longint unsigned sqrt_floor(longint unsigned v);
      longint unsigned root, b;
      root = 0; b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= root + b) begin
          v -= root + b; root = (root >> 1) + b;
        end else root >>= 1;
        b >>= 2;
      end
      return root;
    endfunction

    function logic [15:0] recur();
      longint num, den, q, r, nd;
      num = 2 * longint'(delay) + rem;
      den = 4 * longint'($signed(rcount)) + 1;
      q = num / den; r = num % den;
      nd = longint'(delay) - q;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      rem = r;
      if (nd < 0) nd = 0;
      if (nd > 65535) nd = 65535;
      return nd[15:0];
    endfunction

    function void step_pos();
      sdone++;
      if (!dir) pos++; else pos--;
    endfunction

    function void plan(logic [31:0] raw);
      longint unsigned mag, a, s, d, first, slim, alim, pi2, at10, asq, ax200, t148;
      longint dv;
      pi2 = 64'd628318 * 64'd65536 / 64'd100000;
      at10 = 64'd10 * 100000 * pi2 / 200;
      asq = 64'd200000 * pi2 / 200;
      ax200 = 64'd200 * pi2 / 200;
      t148 = 64'd100000 * 676 * 65536 / 10000;
      dir = raw[31];
      mag = raw[31] ? longint'({1'b0, -raw}) : raw;
      if (raw[31] && mag == 0) mag = 64'h80000000;
      if (mag == 1) begin
        rcount = 32'hFFFFFFFF; ph = tsrg_pkg::PH_DECEL; delay = 1000;
      end else if (mag != 0) begin
        a = acc_r == 0 ? 1 : acc_r;
        s = spd_r == 0 ? 1 : spd_r;
        d = dec_r == 0 ? 1 : dec_r;
        run_delay = sat16(at10 / (s << 16));
        first = sat16((t148 * sqrt_floor((asq << 16) / a)) / (64'd10 << 32));
        slim = s * s * 655360 / (ax200 * a);
        if (slim > 64'hFFFFFFFF) slim = 64'hFFFFFFFF;
        if (slim == 0) slim = 1;
        alim = mag * d / (a + d);
        if (alim == 0) alim = 1;
        if (alim <= slim) dv = longint'(alim) - longint'(mag);
        else dv = -longint'(slim * a / d);
        if (dv == 0) dv = -1;
        dcount = dv[31:0];
        dstart = 32'(longint'(mag) + dv);
        if (first <= run_delay) begin
          delay = run_delay; ph = tsrg_pkg::PH_RUN;
        end else begin
          delay = first[15:0]; ph = tsrg_pkg::PH_ACCEL;
        end
        rcount = 0;
      end
      mov = 1;
    endfunction

    function void full_step();
      logic [15:0] nd;
      nd = 0;
      case (ph)
        tsrg_pkg::PH_STOP: begin
          sdone = 0; rem = 0; mov = 0;
        end
        tsrg_pkg::PH_ACCEL: begin
          step_pos(); rcount++; nd = recur();
          if (sdone >= dstart) begin
            rcount = dcount; ph = tsrg_pkg::PH_DECEL;
          end else if (nd <= run_delay) begin
            last_acc = nd; nd = run_delay; rem = 0; ph = tsrg_pkg::PH_RUN;
          end
        end
        tsrg_pkg::PH_RUN: begin
          step_pos(); nd = run_delay;
          if (sdone >= dstart) begin
            rcount = dcount; nd = last_acc; ph = tsrg_pkg::PH_DECEL;
          end
        end
        default: begin
          step_pos(); rcount++; nd = recur();
          if (!rcount[31]) ph = tsrg_pkg::PH_STOP;
        end
      endcase
      delay = nd;
    endfunction

    function void note_request(logic m, logic [31:0] steps);
      ramp_out_t r;
      if (!m) begin
        plan(steps); r.dly = delay;
      end else begin
        r.dly = delay; tog ^= 1;
        if (!tog) full_step();
      end
      r.pulse = tog; r.dir = dir; r.pos = pos; r.mov = mov; r.ph = ph;
      pending.push_back(r);
    endfunction

    function void check_result(ramp_out_t got);
      ramp_out_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected"); errors++; return;
      end
      e = pending.pop_front();
      if (got.dly !== e.dly) begin
        $error("compare_delay exp %0d got %0d", e.dly, got.dly); errors++;
      end
      if (got.pulse !== e.pulse) begin
        $error("pulse_level exp %0d got %0d", e.pulse, got.pulse); errors++;
      end
      if (got.dir !== e.dir) begin
        $error("direction exp %0d got %0d", e.dir, got.dir); errors++;
      end
      if (got.pos !== e.pos) begin
        $error("position exp %0d got %0d", $signed(e.pos), $signed(got.pos)); errors++;
      end
      if (got.mov !== e.mov) begin
        $error("moving exp %0d got %0d", e.mov, got.mov); errors++;
      end
      if (got.ph !== e.ph) begin
        $error("phase exp %0d got %0d", e.ph, got.ph); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, mode = 0;
  logic signed [31:0] move_steps = 0;
  logic out_valid, out_stall = 0;
  logic [15:0] compare_delay;
  logic pulse_level, direction, moving;
  logic signed [31:0] position;
  logic [1:0] phase;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;

  ramp_scoreboard ramp_sb;
  bit busy_free;
  int cycles;

  trapezoid_step_ramp_generator DUT (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 10000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && in_valid && !in_stall) ramp_sb.note_request(mode, move_steps);

  always @(posedge clk)
    if (!rst && out_valid && !out_stall)
      ramp_sb.check_result({compare_delay, pulse_level, direction, position, moving,
                            tsrg_pkg::phase_t'(phase)});

  always @(negedge clk)
    out_stall <= busy_free ? 1'b0 : ($urandom_range(99) < 25);

  task automatic write_reg(logic [1:0] idx, logic [15:0] v);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= {16'd0, v};
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    ramp_sb.write_reg(idx, v);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic drain();
    while (ramp_sb.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic send(logic m, logic [31:0] s);
    @(negedge clk);
    while (!busy_free && $urandom_range(99) < 25) @(negedge clk);
    in_valid <= 1; mode <= m; move_steps <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic run_move(logic [31:0] s, int extra);
    send(1'b0, s);
    repeat (extra) send(1'b1, $urandom);
  endtask

  int small_steps;

  initial begin
    ramp_sb = new();
    ramp_sb.reset_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed
    send(1'b1, 32'd0); send(1'b1, 32'd0);
    run_move(0, 3);
    run_move(1, 4);
    run_move(32'hFFFFFFFF, 4);
    run_move(32'h80000000, 2);
    run_move(32'h7FFFFFFF, 2);
    run_move(6, 20);
    drain();
    write_reg(tsrg_pkg::REG_ACCEL, 16'd0); write_reg(tsrg_pkg::REG_SPEED, 16'd0);
    write_reg(tsrg_pkg::REG_DECEL, 16'd0);
    run_move(5, 6);
    drain();
    write_reg(tsrg_pkg::REG_ACCEL, 16'hFFFF); write_reg(tsrg_pkg::REG_SPEED, 16'hFFFF);
    write_reg(tsrg_pkg::REG_DECEL, 16'hFFFF);
    run_move(-10, 8);
    drain();
    // random phases with varied register settings
    for (int p = 0; p < 12; p++) begin
      busy_free = (p == 3);
      if (p > 0) begin
        write_reg(tsrg_pkg::REG_ACCEL,
                  p % 4 == 0 ? 16'd1 : 16'($urandom_range(1, 3000)));
        write_reg(tsrg_pkg::REG_SPEED,
                  p % 5 == 0 ? 16'hFFFF : 16'($urandom_range(1, 3000)));
        write_reg(tsrg_pkg::REG_DECEL, 16'($urandom_range(0, 65535)));
      end
      for (int i = 0; i < 8; i++) begin
        small_steps = $urandom_range(1, 16);
        if ($urandom_range(9) == 0) small_steps = -small_steps;
        if ($urandom_range(19) == 0) run_move($urandom, $urandom_range(0, 6));
        else run_move(small_steps, 2 * (small_steps < 0 ? -small_steps : small_steps) +
                      $urandom_range(0, 6));
        if (i == 3) drain();
      end
      drain();
    end
    busy_free = 0;
    drain();
    if (ramp_sb.errors == 0 && ramp_sb.pending.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule

### trapezoid_step_ramp_generator.f
rtl/core/tsrg_pkg.sv
rtl/core/tsrg_divider.sv
rtl/core/tsrg_sqrt.sv
rtl/core/tsrg_mul.sv
rtl/core/trapezoid_step_ramp_generator.sv
tb/tb_trapezoid_step_ramp_generator.sv
